### src/tpse_pkg.sv
// Shared types and constants for the transport stream PSI section extractor.
`timescale 1ns / 1ps

package tpse_pkg;

    // Field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PID_W   = 13;
    localparam int unsigned COUNT_W = 13;

    // Packet framing
    localparam logic [BYTE_W-1:0] SYNC_MARK   = 8'h47;
    localparam logic [BYTE_W-1:0] PACKET_LAST = 8'd187;

    // Header byte positions within a packet
    localparam logic [BYTE_W-1:0] POS_SYNC     = 8'd0;
    localparam logic [BYTE_W-1:0] POS_PID_HI   = 8'd1;
    localparam logic [BYTE_W-1:0] POS_PID_LO   = 8'd2;
    localparam logic [BYTE_W-1:0] POS_FLAGS    = 8'd3;
    localparam logic [BYTE_W-1:0] POS_POINTER  = 8'd4;
    localparam logic [BYTE_W-1:0] POS_LEN_HI   = 8'd6;
    localparam logic [BYTE_W-1:0] POS_LEN_LO   = 8'd7;

    // Bit fields within header bytes
    localparam int unsigned START_BIT = 6;

    // One result beat
    typedef struct packed {
        logic [BYTE_W-1:0] section_byte;
        logic              sync_error;
    } t_result;

    // Result beat with its strobe, parser to output buffer
    typedef struct packed {
        logic    valid;
        t_result data;
    } t_beat;

    // Status of the parser
    typedef struct packed {
        logic halted;
    } t_parse_status;

    // Status of the output buffer
    typedef struct packed {
        logic main_valid;
        logic skid_valid;
    } t_buf_status;

endpackage

### src/tpse_stream_if.sv
// Valid/ready channel interfaces for the input byte stream and the section result stream.
`timescale 1ns / 1ps

interface tpse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ts_byte;

    modport source (output valid, output ts_byte, input ready);
    modport sink   (input valid, input ts_byte, output ready);
endinterface

interface tpse_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] section_byte;
    logic       sync_error;

    modport source (output valid, output section_byte, output sync_error, input ready);
    modport sink   (input valid, input section_byte, input sync_error, output ready);
endinterface

### src/tpse_parser.sv
// Packet header parser and section byte selector, one input beat per cycle while input is accepted.
`timescale 1ns / 1ps

module tpse_parser (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [tpse_pkg::BYTE_W-1:0]      i_byte,
    input  logic [tpse_pkg::PID_W-1:0]       i_target_pid,
    output tpse_pkg::t_beat                  o_beat,
    output tpse_pkg::t_parse_status          o_status
);
    import tpse_pkg::*;

    logic [BYTE_W-1:0]  r_pos,       n_pos;
    logic [4:0]         r_pid_hi,    n_pid_hi;
    logic               r_start,     n_start;
    logic               r_pid_match, n_pid_match;
    logic [3:0]         r_len_hi,    n_len_hi;
    logic [COUNT_W-1:0] r_remain,    n_remain;
    logic               r_halted,    n_halted;

    // Decode the byte at its packet position and pick the result
    always_comb begin
        n_pos       = r_pos;
        n_pid_hi    = r_pid_hi;
        n_start     = r_start;
        n_pid_match = r_pid_match;
        n_len_hi    = r_len_hi;
        n_remain    = r_remain;
        n_halted    = r_halted;
        o_beat      = '0;

        if (i_accept && !r_halted) begin
            n_pos = (r_pos == PACKET_LAST) ? '0 : r_pos + 8'd1;
            unique case (r_pos)
                POS_SYNC: begin
                    // Bad sync: flag once and stop
                    if (i_byte != SYNC_MARK) begin
                        n_halted               = 1'b1;
                        o_beat.valid           = 1'b1;
                        o_beat.data.sync_error = 1'b1;
                    end
                end
                POS_PID_HI: begin
                    n_pid_hi = i_byte[4:0];
                    n_start  = i_byte[START_BIT];
                end
                POS_PID_LO: begin
                    n_pid_match = ({r_pid_hi, i_byte} == i_target_pid);
                end
                POS_FLAGS: begin
                    n_pid_match = r_pid_match;
                end
                default: begin
                    if (r_pid_match) begin
                        if (r_start && r_pos <= POS_LEN_LO) begin
                            // Section header bytes always lie inside the section
                            if (r_pos != POS_POINTER) begin
                                o_beat.valid             = 1'b1;
                                o_beat.data.section_byte = i_byte;
                            end
                            if (r_pos == POS_LEN_HI) begin
                                n_len_hi = i_byte[3:0];
                            end
                            if (r_pos == POS_LEN_LO) begin
                                n_remain = {1'b0, r_len_hi, i_byte};
                            end
                        end else if (r_remain != '0) begin
                            n_remain                 = r_remain - 13'd1;
                            o_beat.valid             = 1'b1;
                            o_beat.data.section_byte = i_byte;
                        end
                    end
                end
            endcase
        end
    end

    assign o_status.halted = r_halted;

    // Hold parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_pid_hi    <= '0;
            r_start     <= 1'b0;
            r_pid_match <= 1'b0;
            r_len_hi    <= '0;
            r_remain    <= '0;
            r_halted    <= 1'b0;
        end else begin
            r_pos       <= n_pos;
            r_pid_hi    <= n_pid_hi;
            r_start     <= n_start;
            r_pid_match <= n_pid_match;
            r_len_hi    <= n_len_hi;
            r_remain    <= n_remain;
            r_halted    <= n_halted;
        end
    end

endmodule

### src/tpse_out_buf.sv
// Two-entry result buffer: output register plus skid stage.
`timescale 1ns / 1ps

module tpse_out_buf (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  tpse_pkg::t_beat          i_beat,
    input  logic                     i_pop_ready,
    output tpse_pkg::t_result        o_data,
    output tpse_pkg::t_buf_status    o_status
);
    import tpse_pkg::*;

    logic    r_main_valid, n_main_valid;
    logic    r_skid_valid, n_skid_valid;
    t_result r_main,       n_main;
    t_result r_skid,       n_skid;
    logic    pop;

    assign pop = r_main_valid && i_pop_ready;

    // Advance skid into main on a pop, otherwise fill the free slot
    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (pop) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_beat.valid;
                n_main       = i_beat.data;
            end
        end else if (i_beat.valid) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_beat.data;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_beat.data;
            end
        end
    end

    // Hold valid flags under reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_data              = r_main;
    assign o_status.main_valid = r_main_valid;
    assign o_status.skid_valid = r_skid_valid;

endmodule

### src/ts_psi_section_extractor_unit.sv
// Top level of the transport stream PSI section extractor.
//
//  Channel   Dir  Payload                      Handshake
//  i_ts      in   ts_byte[7:0]                 valid/ready
//  o_sec     out  section_byte[7:0], sync_err  valid/ready
//  i_cfg_*   in   target_pid[12:0]             write enable, no wait
//
// One byte is taken every cycle while input ready is high; its result, if any,
// is registered in the output register, or in the skid entry if that is held.
// The per-byte work is a position counter and a few compares in the parser.
// Synchronous active-low reset clears the packet position and halt flag.
// A two-entry output buffer lets a result enter the skid entry while the output
// is stalled; input ready drops only when both entries are full.
`timescale 1ns / 1ps

module ts_psi_section_extractor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [tpse_pkg::PID_W-1:0]    i_cfg_data,
    tpse_in_if.sink                       i_ts,
    tpse_out_if.source                    o_sec
);
    import tpse_pkg::*;

    logic [PID_W-1:0] r_target_pid;
    logic             accept;
    t_beat            beat;
    t_parse_status    parse_status;
    t_buf_status      buf_status;
    t_result          out_data;

    // Hold the configured PID
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_pid <= '0;
        end else if (i_cfg_we) begin
            r_target_pid <= i_cfg_data;
        end
    end

    assign i_ts.ready = !buf_status.skid_valid;
    assign accept     = i_ts.valid && i_ts.ready;

    tpse_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_byte       (i_ts.ts_byte),
        .i_target_pid (r_target_pid),
        .o_beat       (beat),
        .o_status     (parse_status)
    );

    tpse_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_beat      (beat),
        .i_pop_ready (o_sec.ready),
        .o_data      (out_data),
        .o_status    (buf_status)
    );

    assign o_sec.valid        = buf_status.main_valid;
    assign o_sec.section_byte = out_data.section_byte;
    assign o_sec.sync_error   = out_data.sync_error;

    // Skid entry is only ever filled behind a full output register
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        buf_status.skid_valid |-> buf_status.main_valid)
        else $error("skid entry valid with output register empty");

    // An error beat carries a zero byte
    a_error_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_sec.valid && o_sec.sync_error) |-> (o_sec.section_byte == '0))
        else $error("sync error beat with non-zero byte");

    // Once halted, no further beat is produced
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        parse_status.halted |-> !beat.valid)
        else $error("result produced after halt");

    // Input back-pressure only with a beat waiting on the output
    a_ready_low_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ts.ready |-> o_sec.valid)
        else $error("input stalled with output empty");

endmodule

### bench/tb_ts_psi_section_extractor_unit.sv
// Testbench for the PSI section extractor: packet stimulus, byte-level predictor, beat checker.
`timescale 1ns / 1ps

module tb_ts_psi_section_extractor_unit;
    import tpse_pkg::*;

    localparam logic [BYTE_W-1:0] POS_SECTION_FIRST = 8'd5;
    localparam int unsigned       STALL_LIMIT       = 2000;
    localparam int unsigned       LONG_HOLD_AT      = 600;
    localparam int unsigned       LONG_HOLD_CYCLES  = 100;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [PID_W-1:0]   i_cfg_data;

    tpse_in_if  ts_bus ();
    tpse_out_if sec_bus ();

    ts_psi_section_extractor_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ts       (ts_bus),
        .o_sec      (sec_bus)
    );

    // Stream bytes still to offer, front is the one on the bus
    logic [BYTE_W-1:0] stream_bytes[$];
    // Section beats the block still owes
    t_result           owed_sections[$];

    int unsigned fail_count;
    int unsigned bytes_taken;
    int unsigned stall_cycles;
    int unsigned src_gap;
    int unsigned sink_gap;
    int unsigned hold_left;
    bit          long_hold_done;
    bit          src_steady;
    bit          sink_steady;

    // Shadow of the extractor state
    logic [PID_W-1:0]   trk_target_pid;
    logic [BYTE_W-1:0]  trk_pos;
    logic [4:0]         trk_pid_hi;
    logic               trk_start;
    logic               trk_match;
    logic [3:0]         trk_len_hi;
    logic [COUNT_W-1:0] trk_remaining;
    logic               trk_halted;

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        fail_count++;
    endtask

    // Advance the shadow state by one byte and queue the beat it owes, if any
    task automatic track_byte(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] pos;
        t_result           beat;
        beat.section_byte = b;
        beat.sync_error   = 1'b0;
        if (!trk_halted) begin
            pos     = trk_pos;
            trk_pos = (pos == PACKET_LAST) ? 8'd0 : pos + 8'd1;
            if (pos == POS_SYNC) begin
                if (b != SYNC_MARK) begin
                    trk_halted        = 1'b1;
                    beat.section_byte = '0;
                    beat.sync_error   = 1'b1;
                    owed_sections.push_back(beat);
                end
            end else if (pos == POS_PID_HI) begin
                trk_pid_hi = b[4:0];
                trk_start  = b[START_BIT];
            end else if (pos == POS_PID_LO) begin
                trk_match = ({trk_pid_hi, b} == trk_target_pid);
            end else if (pos == POS_FLAGS || !trk_match) begin
                // header byte or foreign packet: nothing out
            end else if (trk_start && pos == POS_POINTER) begin
                // pointer field is never passed on
            end else if (trk_start && pos >= POS_SECTION_FIRST && pos <= POS_LEN_LO) begin
                if (pos == POS_LEN_HI)
                    trk_len_hi = b[3:0];
                if (pos == POS_LEN_LO)
                    trk_remaining = {1'b0, trk_len_hi, b};
                owed_sections.push_back(beat);
            end else if (trk_remaining != '0) begin
                trk_remaining = trk_remaining - 13'd1;
                owed_sections.push_back(beat);
            end
        end
    endtask

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic logic [11:0] draw_len();
        if ($urandom_range(0, 7) == 0)
            return 12'($urandom_range(0, 4095));
        return 12'($urandom_range(0, 200));
    endfunction

    // Queue one full 188-byte packet with the given header fields
    task automatic add_packet(input logic [PID_W-1:0] pid, input logic start,
                              input logic [11:0] sec_len);
        logic [BYTE_W-1:0] b;
        for (int i = 0; i <= int'(PACKET_LAST); i++) begin
            b = 8'($urandom_range(0, 255));
            case (i)
                0: b = SYNC_MARK;
                1: begin
                    b[4:0]      = pid[12:8];
                    b[START_BIT] = start;
                end
                2: b = pid[7:0];
                6: b[3:0] = sec_len[11:8];
                7: b = sec_len[7:0];
                default: ;
            endcase
            stream_bytes.push_back(b);
        end
    endtask

    task automatic add_random_packet(input logic [PID_W-1:0] pid);
        int unsigned kind;
        kind = $urandom_range(0, 99);
        if (kind < 50)
            add_packet(pid, 1'b1, draw_len());
        else if (kind < 75)
            add_packet(pid, 1'b0, draw_len());
        else if (kind < 90)
            add_packet(pid ^ PID_W'($urandom_range(1, 8191)), 1'($urandom_range(0, 1)),
                       draw_len());
        else
            add_packet(PID_W'($urandom_range(0, 8191)), 1'($urandom_range(0, 1)), draw_len());
    endtask

    // Write the PID register; only called while the block is idle
    task automatic set_target(input logic [PID_W-1:0] pid);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= pid;
        trk_target_pid = pid;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Hold off until every byte is taken and every owed beat has come out
    task automatic drain();
        while (stream_bytes.size() != 0 || owed_sections.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Source side: offer queued bytes, hold on stall, insert random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ts_bus.valid   <= 1'b0;
            ts_bus.ts_byte <= '0;
            src_gap        <= 0;
            bytes_taken    <= 0;
        end else begin : drive
            logic taken;
            taken = ts_bus.valid && ts_bus.ready;
            if (taken) begin
                track_byte(ts_bus.ts_byte);
                void'(stream_bytes.pop_front());
                bytes_taken <= bytes_taken + 1;
            end
            if (ts_bus.valid && !taken) begin
                // hold the beat until it is taken
            end else if (taken && !src_steady && $urandom_range(0, 99) < 25) begin
                src_gap      <= draw_gap() - 1;
                ts_bus.valid <= 1'b0;
            end else if (src_gap != 0) begin
                src_gap      <= src_gap - 1;
                ts_bus.valid <= 1'b0;
            end else if (stream_bytes.size() != 0) begin
                ts_bus.valid   <= 1'b1;
                ts_bus.ts_byte <= stream_bytes[0];
            end else begin
                ts_bus.valid <= 1'b0;
            end
        end
    end

    // Sink side: random back-pressure plus one long hold to fill the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sec_bus.ready  <= 1'b0;
            sink_gap       <= 0;
            hold_left      <= 0;
            long_hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left     <= hold_left - 1;
            sec_bus.ready <= 1'b0;
        end else if (!long_hold_done && bytes_taken >= LONG_HOLD_AT) begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD_CYCLES - 1;
            sec_bus.ready  <= 1'b0;
        end else if (sink_steady) begin
            sec_bus.ready <= 1'b1;
        end else if (sink_gap != 0) begin
            sink_gap      <= sink_gap - 1;
            sec_bus.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < 15) begin
            sink_gap      <= draw_gap() - 1;
            sec_bus.ready <= 1'b0;
        end else begin
            sec_bus.ready <= 1'b1;
        end
    end

    // Check each result beat against the oldest owed one
    always @(posedge i_clk) begin
        if (i_rst_n && sec_bus.valid && sec_bus.ready) begin : check
            t_result want;
            if (owed_sections.size() == 0) begin
                report_mismatch($sformatf("unexpected beat byte=%02h err=%0b",
                                          sec_bus.section_byte, sec_bus.sync_error));
            end else begin
                want = owed_sections.pop_front();
                if (sec_bus.section_byte !== want.section_byte)
                    report_mismatch($sformatf("section_byte %02h, want %02h",
                                              sec_bus.section_byte, want.section_byte));
                if (sec_bus.sync_error !== want.sync_error)
                    report_mismatch($sformatf("sync_error %0b, want %0b",
                                              sec_bus.sync_error, want.sync_error));
            end
        end
    end

    // Drop the run if neither side moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (ts_bus.valid && ts_bus.ready) || (sec_bus.valid && sec_bus.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("ts_psi_section_extractor_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        logic [PID_W-1:0]  pid;
        logic [BYTE_W-1:0] bad;
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_data     = '0;
        fail_count     = 0;
        src_steady     = 1'b0;
        sink_steady    = 1'b0;
        trk_target_pid = '0;
        trk_pos        = '0;
        trk_pid_hi     = '0;
        trk_start      = 1'b0;
        trk_match      = 1'b0;
        trk_len_hi     = '0;
        trk_remaining  = '0;
        trk_halted     = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset PID 0: continuation before any start, shortest section, foreign PID
        add_packet(13'h0000, 1'b0, draw_len());
        add_packet(13'h0000, 1'b1, 12'h000);
        add_packet(13'h1FFF, 1'b1, 12'h005);
        drain();

        // Top PID: longest section, then a restart with a one-byte body
        set_target(13'h1FFF);
        @(negedge i_clk);
        add_packet(13'h1FFF, 1'b1, 12'hFFF);
        add_packet(13'h1FFF, 1'b1, 12'h001);
        drain();

        // Random packets over several PID settings; second phase runs without gaps
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: pid = 13'h0000;
                1: pid = 13'h1FFF;
                default: pid = PID_W'($urandom_range(0, 8191));
            endcase
            set_target(pid);
            @(negedge i_clk);
            src_steady  = (ph == 1);
            sink_steady = (ph == 1);
            add_random_packet(pid);
            drain();
        end

        // Bad sync byte halts the block; later bytes are swallowed
        src_steady  = 1'b0;
        sink_steady = 1'b0;
        do
            bad = 8'($urandom_range(0, 255));
        while (bad == SYNC_MARK);
        stream_bytes.push_back(bad);
        repeat (20) stream_bytes.push_back(8'($urandom_range(0, 255)));
        drain();
        repeat (10) @(negedge i_clk);

        if (owed_sections.size() != 0)
            report_mismatch($sformatf("%0d beats never came out", owed_sections.size()));
        if (fail_count == 0)
            $display("ts_psi_section_extractor_unit regression: pass");
        else
            $display("ts_psi_section_extractor_unit regression: fail");
        $finish;
    end

endmodule
